>>> hdl/plcl_pkg.sv
// ============================================================================
// plcl_pkg
// Shared constants, codes and types of the per-lane concurrency limiter.
// ============================================================================
package plcl_pkg;

   localparam int LaneCount    = 8;
   localparam int BacklogDepth = 16;
   localparam int MaxResults   = 16;
   localparam int QueueDepth   = 2;

   localparam int TaskW   = 16;
   localparam int LaneIdW = 3;
   localparam int ThreadW = 7;
   localparam int RunW    = 6;
   localparam int LaneW   = $clog2(LaneCount);
   localparam int SlotW   = $clog2(BacklogDepth);
   localparam int FillW   = $clog2(BacklogDepth + 1);
   localparam int CntW    = $clog2(MaxResults + 1);
   localparam int AddrW   = LaneW + SlotW;
   localparam int QPtrW   = $clog2(QueueDepth);
   localparam int QCntW   = $clog2(QueueDepth + 1);

   localparam logic [ThreadW-1:0] ThreadReset = ThreadW'(8);

   localparam logic CMD_SUBMIT  = 1'b0;
   localparam logic CMD_FINISH  = 1'b1;
   localparam logic KIND_START  = 1'b0;
   localparam logic KIND_REJECT = 1'b1;

   typedef enum logic [1:0] {
      OP_FREE_START,
      OP_LANE_SUBMIT,
      OP_LANE_FINISH
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DRAIN_CHECK,
      ST_DRAIN_EMIT
   } state_type;

   typedef struct packed {
      op_type               op;
      logic [TaskW-1:0]     task_id;
      logic [LaneIdW-1:0]   lane_id;
   } q_item_type;

   typedef struct packed {
      logic       valid;
      q_item_type item;
   } q_head_type;

endpackage

>>> hdl/plcl_if.sv
// ============================================================================
// plcl_if
// Request and response channels of the per-lane concurrency limiter.
// ============================================================================
interface plcl_req_if;
   import plcl_pkg::*;

   logic               valid;
   logic               ready;
   logic               cmd;
   logic [TaskW-1:0]   task_id;
   logic               has_lane;
   logic [LaneIdW-1:0] lane_id;

   modport source (output valid, cmd, task_id, has_lane, lane_id, input ready);
   modport sink   (input valid, cmd, task_id, has_lane, lane_id, output ready);
endinterface

interface plcl_rsp_if;
   import plcl_pkg::*;

   logic               valid;
   logic               ready;
   logic               kind;
   logic [TaskW-1:0]   out_task;
   logic               out_in_lane;
   logic [LaneIdW-1:0] out_lane;
   logic               last;

   modport source (output valid, kind, out_task, out_in_lane, out_lane, last,
                   input ready);
   modport sink   (input valid, kind, out_task, out_in_lane, out_lane, last,
                   output ready);
endinterface

>>> hdl/per_lane_concurrency_limiter.sv
// ============================================================================
// per_lane_concurrency_limiter
// Admits tasks under a per-lane limit of max(1, thread_count/2), with a FIFO
// backlog per lane and a drain of waiting tasks on each finish.
// ============================================================================
// The front end takes one request beat per cycle into a two-entry queue while
// the queue has room; the back end executes one command at a time. A submit
// passes through the queue, the execute state and the response register to
// its response beat; a submit that is backlogged gives no beat. A finish
// reads the lane's backlog memory and then issues the beat for each started
// task, up to sixteen tasks. The backlog memory needs no clearing pass.
module per_lane_concurrency_limiter (
   input  logic                         clock,
   input  logic                         reset,
   plcl_req_if.sink                     req_if,
   plcl_rsp_if.source                   rsp_if,
   input  logic                         csr_wr_en,
   input  logic [plcl_pkg::ThreadW-1:0] csr_wr_data
);
   import plcl_pkg::*;

   q_head_type q_head;
   logic       q_pop;

   plcl_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .q_head (q_head),
      .q_pop  (q_pop)
   );

   plcl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_if      (rsp_if)
   );

`ifndef ASSERT_OFF
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head.valid)
      else $error("queue popped while empty");

   a_reject_in_lane: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.kind == KIND_REJECT) |-> rsp_if.out_in_lane)
      else $error("reject beat without a lane");

   a_free_lane_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.out_in_lane) |-> (rsp_if.out_lane == '0))
      else $error("lane field set on a task without a lane");

   a_reset_clears_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("response valid after reset");
`endif

endmodule

>>> hdl/plcl_front.sv
// ============================================================================
// plcl_front
// Accepts request beats, classifies them and holds them in a short queue.
// ============================================================================
module plcl_front (
   input  logic                 clock,
   input  logic                 reset,
   plcl_req_if.sink             req_if,
   output plcl_pkg::q_head_type q_head,
   input  logic                 q_pop
);
   import plcl_pkg::*;

   q_item_type             entries_ff [QueueDepth];
   logic [QPtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]       count_ff, count_in;
   logic                   accept;
   logic                   push;
   q_item_type             new_item;

   assign req_if.ready = (count_ff != QCntW'(QueueDepth));
   assign accept       = req_if.valid && req_if.ready;
   assign push         = accept && !(req_if.cmd == CMD_FINISH && !req_if.has_lane);

   always_comb begin
      new_item.task_id = req_if.task_id;
      new_item.lane_id = req_if.lane_id;
      if (req_if.cmd == CMD_FINISH) begin
         new_item.op = OP_LANE_FINISH;
      end else if (req_if.has_lane) begin
         new_item.op = OP_LANE_SUBMIT;
      end else begin
         new_item.op = OP_FREE_START;
      end
   end

   always_comb begin
      wr_ptr_in = push  ? QPtrW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? QPtrW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = QCntW'(count_ff + 1'b1);
      end else if (!push && q_pop) begin
         count_in = QCntW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign q_head.valid = (count_ff != '0);
   assign q_head.item  = entries_ff[rd_ptr_ff];

endmodule

>>> hdl/plcl_back.sv
// ============================================================================
// plcl_back
// Executes queued commands against per-lane counts and backlogs and drives
// the response register.
// ============================================================================
module plcl_back (
   input  logic                        clock,
   input  logic                        reset,
   input  plcl_pkg::q_head_type        q_head,
   output logic                        q_pop,
   input  logic                        csr_wr_en,
   input  logic [plcl_pkg::ThreadW-1:0] csr_wr_data,
   plcl_rsp_if.source                  rsp_if
);
   import plcl_pkg::*;

   state_type            state_ff, state_in;
   q_item_type           cur_ff, cur_in;
   logic [ThreadW-1:0]   thread_ff;
   logic [RunW-1:0]      running_ff [LaneCount];
   logic [RunW-1:0]      running_in [LaneCount];
   logic [SlotW-1:0]     head_ff [LaneCount];
   logic [SlotW-1:0]     head_in [LaneCount];
   logic [FillW-1:0]     fill_ff [LaneCount];
   logic [FillW-1:0]     fill_in [LaneCount];
   logic [CntW-1:0]      drain_cnt_ff, drain_cnt_in;
   logic [TaskW-1:0]     mem [LaneCount * BacklogDepth];
   logic [TaskW-1:0]     rd_data_ff;
   logic                 mem_we;
   logic                 rd_en;
   logic [AddrW-1:0]     wr_addr;
   logic [AddrW-1:0]     rd_addr;

   logic                 rsp_valid_ff;
   logic                 rsp_kind_ff;
   logic [TaskW-1:0]     rsp_task_ff;
   logic                 rsp_in_lane_ff;
   logic [LaneIdW-1:0]   rsp_lane_ff;
   logic                 rsp_last_ff;

   logic                 emit;
   logic                 emit_kind;
   logic [TaskW-1:0]     emit_task;
   logic                 emit_in_lane;
   logic [LaneIdW-1:0]   emit_lane;
   logic                 emit_last;

   logic [RunW-1:0]      half;
   logic [RunW-1:0]      limit;
   logic [LaneW-1:0]     ln;
   logic                 out_free;

   assign half     = thread_ff[ThreadW-1:1];
   assign limit    = (half == '0) ? RunW'(1) : half;
   assign ln       = cur_ff.lane_id[LaneW-1:0];
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign wr_addr  = {ln, SlotW'(head_ff[ln] + fill_ff[ln][SlotW-1:0])};
   assign rd_addr  = {ln, head_ff[ln]};

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      running_in   = running_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      drain_cnt_in = drain_cnt_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      emit         = 1'b0;
      emit_kind    = KIND_START;
      emit_task    = cur_ff.task_id;
      emit_in_lane = 1'b1;
      emit_lane    = cur_ff.lane_id;
      emit_last    = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               q_pop    = 1'b1;
               cur_in   = q_head.item;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (cur_ff.op)
               OP_FREE_START: begin
                  if (out_free) begin
                     emit         = 1'b1;
                     emit_in_lane = 1'b0;
                     emit_lane    = '0;
                     state_in     = ST_IDLE;
                  end
               end
               OP_LANE_SUBMIT: begin
                  if (running_ff[ln] < limit) begin
                     if (out_free) begin
                        emit           = 1'b1;
                        running_in[ln] = RunW'(running_ff[ln] + 1'b1);
                        state_in       = ST_IDLE;
                     end
                  end else if (fill_ff[ln] < FillW'(BacklogDepth)) begin
                     mem_we      = 1'b1;
                     fill_in[ln] = FillW'(fill_ff[ln] + 1'b1);
                     state_in    = ST_IDLE;
                  end else if (out_free) begin
                     emit      = 1'b1;
                     emit_kind = KIND_REJECT;
                     state_in  = ST_IDLE;
                  end
               end
               OP_LANE_FINISH: begin
                  if (running_ff[ln] != '0) begin
                     running_in[ln] = RunW'(running_ff[ln] - 1'b1);
                  end
                  drain_cnt_in = '0;
                  state_in     = ST_DRAIN_CHECK;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_DRAIN_CHECK: begin
            if (drain_cnt_ff < CntW'(MaxResults) && running_ff[ln] < limit
                && fill_ff[ln] != '0) begin
               rd_en    = 1'b1;
               state_in = ST_DRAIN_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DRAIN_EMIT: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_task = rd_data_ff;
               emit_last = (drain_cnt_ff == CntW'(MaxResults - 1))
                           || (running_ff[ln] >= RunW'(limit - 1'b1))
                           || (fill_ff[ln] == FillW'(1));
               head_in[ln]    = SlotW'(head_ff[ln] + 1'b1);
               fill_in[ln]    = FillW'(fill_ff[ln] - 1'b1);
               running_in[ln] = RunW'(running_ff[ln] + 1'b1);
               drain_cnt_in   = CntW'(drain_cnt_ff + 1'b1);
               state_in       = emit_last ? ST_IDLE : ST_DRAIN_CHECK;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thread_ff    <= ThreadReset;
         drain_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LaneCount; i++) begin
            running_ff[i] <= '0;
            head_ff[i]    <= '0;
            fill_ff[i]    <= '0;
         end
      end else begin
         state_ff     <= state_in;
         drain_cnt_ff <= drain_cnt_in;
         running_ff   <= running_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         if (csr_wr_en) begin
            thread_ff <= csr_wr_data;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         rsp_kind_ff    <= emit_kind;
         rsp_task_ff    <= emit_task;
         rsp_in_lane_ff <= emit_in_lane;
         rsp_lane_ff    <= emit_lane;
         rsp_last_ff    <= emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= cur_ff.task_id;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.kind        = rsp_kind_ff;
   assign rsp_if.out_task    = rsp_task_ff;
   assign rsp_if.out_in_lane = rsp_in_lane_ff;
   assign rsp_if.out_lane    = rsp_lane_ff;
   assign rsp_if.last        = rsp_last_ff;

endmodule
